FILE: sv/gmnc_pkg.sv
// Shared types, constants and GF(2) matrix functions of the nibble codec.
`default_nettype none

package gmnc_pkg;

	// Fixed geometry of the key matrix.
	localparam int MsgBits  = 4;
	localparam int CodeBits = 8;
	localparam int KeyWidth = MsgBits * CodeBits;
	localparam int DataW    = 32;
	localparam int AddrW    = 3;

	// Default depth of the result queue.
	localparam int OutDepth = 4;

	// Register index, taken from bit 2 of the byte address.
	typedef enum logic [0:0] {
		REG_KEY  = 1'b0,
		REG_MODE = 1'b1
	} reg_idx_t;

	// Register contents seen by the datapath, plus the pair clear pulse.
	typedef struct packed {
		logic [KeyWidth-1:0] key;
		logic                decode_mode;
		logic                pair_clear;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic [CodeBits-1:0] out_byte;
		logic                last;
		logic                key_error;
	} res_t;

	// Results handed from the datapath to the queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Row r of the key; row 0 sits in the top byte.
	function automatic logic [CodeBits-1:0] key_row(input logic [KeyWidth-1:0] key,
			input int r);
		return key[KeyWidth-1-CodeBits*r -: CodeBits];
	endfunction

	// Column k of the key as a vector with bit r taken from row r.
	function automatic logic [MsgBits-1:0] key_col(input logic [KeyWidth-1:0] key,
			input int k);
		logic [MsgBits-1:0] v;
		v = '0;
		for (int r = 0; r < MsgBits; r++) begin
			v[r] = key[KeyWidth-1-CodeBits*r-k];
		end
		return v;
	endfunction

	// Code byte: XOR of the rows selected by the nibble, bit 3 selecting row 0.
	function automatic logic [CodeBits-1:0] encode_nibble(input logic [KeyWidth-1:0] key,
			input logic [MsgBits-1:0] nib);
		logic [CodeBits-1:0] acc;
		acc = '0;
		for (int r = 0; r < MsgBits; r++) begin
			if (nib[MsgBits-1-r]) begin
				acc = acc ^ key_row(key, r);
			end
		end
		return acc;
	endfunction

	// Recovered nibble in the low bits and a missing-column flag on top.
	// Each message bit comes from the first column equal to its unit vector.
	function automatic logic [MsgBits:0] decode_nibble(input logic [KeyWidth-1:0] key,
			input logic [CodeBits-1:0] code);
		logic [MsgBits-1:0] nib;
		logic               err;
		logic               found;
		nib = '0;
		err = 1'b0;
		for (int j = 0; j < MsgBits; j++) begin
			found = 1'b0;
			for (int k = 0; k < CodeBits; k++) begin
				if (!found && (key_col(key, k) == (MsgBits'(1) << j))) begin
					found             = 1'b1;
					nib[MsgBits-1-j]  = code[CodeBits-1-k];
				end
			end
			if (!found) begin
				err = 1'b1;
			end
		end
		return {err, nib};
	endfunction

endpackage

`default_nettype wire

FILE: sv/gmnc_apb_regs.sv
// APB register file holding the key matrix and the mode bit.
`default_nettype none

module gmnc_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [gmnc_pkg::AddrW-1:0]  paddr,
	input  wire logic [gmnc_pkg::DataW-1:0]  pwdata,
	output logic      [gmnc_pkg::DataW-1:0]  prdata,
	output logic                             pready,
	output gmnc_pkg::cfg_t                   cfg
);

	logic [gmnc_pkg::KeyWidth-1:0] key_q;
	logic                          mode_q;
	logic                          wr_en;
	gmnc_pkg::reg_idx_t            idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = gmnc_pkg::reg_idx_t'(paddr[2]);

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				gmnc_pkg::REG_KEY:  key_q  <= pwdata[gmnc_pkg::KeyWidth-1:0];
				gmnc_pkg::REG_MODE: mode_q <= pwdata[0];
				default:            key_q  <= key_q;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (idx)
			gmnc_pkg::REG_KEY:  prdata = key_q;
			gmnc_pkg::REG_MODE: prdata = {{(gmnc_pkg::DataW-1){1'b0}}, mode_q};
			default:            prdata = '0;
		endcase
	end

	// A mode write drops any half-received decode pair.
	assign cfg.key         = key_q;
	assign cfg.decode_mode = mode_q;
	assign cfg.pair_clear  = wr_en && (idx == gmnc_pkg::REG_MODE);

endmodule

`default_nettype wire

FILE: sv/gmnc_core.sv
// Input register, encode and decode logic, and decode pair state.
`default_nettype none

module gmnc_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [gmnc_pkg::CodeBits-1:0]  data_byte,
	input  wire gmnc_pkg::cfg_t                 cfg,
	input  wire logic                           room,
	output gmnc_pkg::push_t                     push
);

	logic                           valid_s1;
	logic [gmnc_pkg::CodeBits-1:0]  byte_s1;
	logic                           second_half_q;
	logic [gmnc_pkg::MsgBits-1:0]   held_nibble_q;
	logic                           held_error_q;
	logic                           accept;
	logic                           advance;
	logic [gmnc_pkg::CodeBits-1:0]  enc_hi;
	logic [gmnc_pkg::CodeBits-1:0]  enc_lo;
	logic [gmnc_pkg::MsgBits:0]     dec;

	// The input register moves on whenever the queue can take two beats.
	assign advance  = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	// Matrix products for the held byte.
	assign enc_hi = gmnc_pkg::encode_nibble(cfg.key, byte_s1[7:4]);
	assign enc_lo = gmnc_pkg::encode_nibble(cfg.key, byte_s1[3:0]);
	assign dec    = gmnc_pkg::decode_nibble(cfg.key, byte_s1);

	// Result beats produced by the byte leaving the input register.
	always_comb begin
		push.cnt = 2'd0;
		push.r0  = '{out_byte: enc_hi, last: 1'b0, key_error: 1'b0};
		push.r1  = '{out_byte: enc_lo, last: 1'b1, key_error: 1'b0};
		if (advance) begin
			if (!cfg.decode_mode) begin
				push.cnt = 2'd2;
			end else if (second_half_q) begin
				push.cnt = 2'd1;
				push.r0  = '{out_byte: {held_nibble_q, dec[gmnc_pkg::MsgBits-1:0]},
						last: 1'b1,
						key_error: dec[gmnc_pkg::MsgBits] | held_error_q};
			end
		end
	end

	// Decode pair state: the first byte is held, the second completes the pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_half_q <= 1'b0;
			held_nibble_q <= '0;
			held_error_q  <= 1'b0;
		end else if (cfg.pair_clear) begin
			second_half_q <= 1'b0;
			held_nibble_q <= '0;
			held_error_q  <= 1'b0;
		end else if (advance && cfg.decode_mode) begin
			if (second_half_q) begin
				second_half_q <= 1'b0;
				held_nibble_q <= '0;
				held_error_q  <= 1'b0;
			end else begin
				second_half_q <= 1'b1;
				held_nibble_q <= dec[gmnc_pkg::MsgBits-1:0];
				held_error_q  <= dec[gmnc_pkg::MsgBits];
			end
		end
	end

	// A byte held back for lack of queue space keeps its value.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register changed while held");

	// A mode write leaves no half pair behind.
	a_pair_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.pair_clear |=> !second_half_q)
		else $error("pair state survived a mode write");

	// Encoding always produces two beats per byte; decoding at most one.
	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (cfg.decode_mode ? (push.cnt != 2'd2) : (push.cnt == 2'd2)))
		else $error("wrong number of result beats");

endmodule

`default_nettype wire

FILE: sv/gmnc_out_fifo.sv
// Result queue taking up to two beats a cycle and sending one while out_stall is low.
`default_nettype none

module gmnc_out_fifo #(
	parameter int DEPTH = gmnc_pkg::OutDepth
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire gmnc_pkg::push_t                push,
	output logic                                room,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [gmnc_pkg::CodeBits-1:0]       out_byte,
	output logic                                last,
	output logic                                key_error
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	gmnc_pkg::res_t   mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic [PtrW-1:0]  wr_ptr1;
	logic [PtrW-1:0]  wr_ptr2;
	logic             pop;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr1   = ptr_inc(wr_ptr_q);
	assign wr_ptr2   = ptr_inc(wr_ptr1);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign room      = (count_q <= CntW'(DEPTH - 2));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr1] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push.cnt)
				2'd1:    wr_ptr_q <= wr_ptr1;
				2'd2:    wr_ptr_q <= wr_ptr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push.cnt) - CntW'(pop);
		end
	end

	// Head entry drives the output beat.
	assign out_byte  = mem_q[rd_ptr_q].out_byte;
	assign last      = mem_q[rd_ptr_q].last;
	assign key_error = mem_q[rd_ptr_q].key_error;

	// The fill count never passes the depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("result queue overfilled");

	// Beats are only pushed where they fit.
	a_push_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> ((int'(count_q) + int'(push.cnt)) <= DEPTH))
		else $error("push into a full result queue");

	// A stalled head beat stays offered and unchanged.
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(last)
			&& $stable(key_error)))
		else $error("head beat changed while stalled");

endmodule

`default_nettype wire

FILE: sv/gf2_matrix_nibble_codec.sv
// Nibble codec: GF(2) matrix encoder and decoder with an APB register port.
//
// Usage: write the 32-bit key matrix at address 0 and the mode bit at
// address 4 while the block is idle; a mode write drops a half-received
// decode pair. Bytes enter on in_valid/in_stall/data_byte and results leave
// on out_valid/out_stall with out_byte, last and key_error; a beat moves at
// an edge where valid is high and stall is low.
// Encode: each input byte gives two beats, the high nibble's code byte first
// (last low) and then the low nibble's (last high). Decode: bytes pair up,
// the second byte of each pair giving one beat with last high; key_error
// flags a key with no matching identity column.
// A byte is held in the input register, and its result beats are written into
// the result queue and offered from there, an encode's high beat first.
// Throughput: the output sends one beat per cycle while out_stall is low;
// decoding takes a byte every cycle while the queue has two free entries.
// Reset clears the registers, the pair state and the result queue. When the
// receiver stalls, the queue of OUT_DEPTH beats fills; in_stall rises while a
// byte waits in the input register and fewer than two entries are free, and
// nothing is lost.
`default_nettype none

module gf2_matrix_nibble_codec #(
	parameter int OUT_DEPTH = gmnc_pkg::OutDepth
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [gmnc_pkg::AddrW-1:0]     paddr,
	input  wire logic [gmnc_pkg::DataW-1:0]     pwdata,
	output logic      [gmnc_pkg::DataW-1:0]     prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [gmnc_pkg::CodeBits-1:0]  data_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [gmnc_pkg::CodeBits-1:0]  out_byte,
	output logic                                last,
	output logic                                key_error
);

	gmnc_pkg::cfg_t  cfg;
	gmnc_pkg::push_t push;
	logic            room;

	// Configuration registers.
	gmnc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register and matrix logic.
	gmnc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.cfg       (cfg),
		.room      (room),
		.push      (push)
	);

	// Result queue toward the receiver.
	gmnc_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.key_error (key_error)
	);

endmodule

`default_nettype wire
